/* rtl/core/nearest_neighbor_image_scaler_defines.svh */
// assertion macros for the nearest-neighbor image scaler checker
// expects clk and rst in the scope where a macro is used
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_DEFINES_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_DEFINES_SVH

// same-cycle implication, off during reset
`define NNIS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nnis same-cycle check failed");

// next-cycle implication, off during reset
`define NNIS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nnis next-cycle check failed");

`endif

/* rtl/core/nnis_pkg.sv */
// shared types and constants for the nearest-neighbor image scaler
// no dependencies
package nnis_pkg;

  localparam int PIX_W       = 32;
  localparam int SIDE_W      = 6;
  localparam int STORE_SIDE  = 64;
  localparam int STORE_DEPTH = STORE_SIDE * STORE_SIDE;
  localparam int DIM_REG_W   = 7;
  localparam int FACTOR_BITS = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int DIV_W       = 16;
  localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_W  = 3'd0,
    CFG_SRC_H  = 3'd1,
    CFG_FACTOR = 3'd2,
    CFG_FIT    = 3'd3,
    CFG_TGT_W  = 3'd4,
    CFG_TGT_H  = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_FIT_W,
    DIV_FIT_H,
    DIV_MAP_X,
    DIV_MAP_Y
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FW_GO,
    ST_FW_WAIT,
    ST_FH_GO,
    ST_FH_WAIT,
    ST_DIMS,
    ST_CHECK,
    ST_MX_GO,
    ST_MX_WAIT,
    ST_MY_GO,
    ST_MY_WAIT,
    ST_FETCH,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic     store;
    logic     capture;
    logic     factor_cfg;
    logic     div_start;
    div_sel_t div_sel;
    logic     fit_w_save;
    logic     fit_h_save;
    logic     dims_save;
    logic     check_save;
    logic     map_x_save;
    logic     map_y_save;
    logic     fetch;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic fit_mode;
    logic div_done;
    logic hit;
  } status_t;

endpackage

/* rtl/core/nnis_div.sv */
// restoring divider, one quotient bit per cycle
// depends on nnis_pkg
module nnis_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [nnis_pkg::DIV_W-1:0] dividend,
  input  logic [nnis_pkg::DIV_W-1:0] divisor,
  output logic [nnis_pkg::DIV_W-1:0] quotient,
  output logic                      done
);
  import nnis_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dvs;
  logic [DIV_W:0]       shifted;
  logic                 fits;

  assign shifted = {rem, quotient[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      if (fits) begin
        rem      <= DIV_W'(shifted - {1'b0, dvs});
        quotient <= {quotient[DIV_W-2:0], 1'b1};
      end else begin
        rem      <= shifted[DIV_W-1:0];
        quotient <= {quotient[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/core/nnis_ctrl.sv */
// controller state machine for the scaler
// depends on nnis_pkg
module nnis_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              opcode,
  output logic              out_valid,
  input  logic              out_ready,
  input  nnis_pkg::status_t status,
  output nnis_pkg::cmd_t    cmd
);
  import nnis_pkg::*;

  state_t state;
  state_t state_next;
  logic   is_read;

  assign is_read = (opcode == OP_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && is_read) begin
          state_next = status.fit_mode ? ST_FW_GO : ST_DIMS;
        end
      end
      ST_FW_GO:   state_next = ST_FW_WAIT;
      ST_FW_WAIT: if (status.div_done) state_next = ST_FH_GO;
      ST_FH_GO:   state_next = ST_FH_WAIT;
      ST_FH_WAIT: if (status.div_done) state_next = ST_DIMS;
      ST_DIMS:    state_next = ST_CHECK;
      ST_CHECK:   state_next = status.hit ? ST_MX_GO : ST_RESULT;
      ST_MX_GO:   state_next = ST_MX_WAIT;
      ST_MX_WAIT: if (status.div_done) state_next = ST_MY_GO;
      ST_MY_GO:   state_next = ST_MY_WAIT;
      ST_MY_WAIT: if (status.div_done) state_next = ST_FETCH;
      ST_FETCH:   state_next = ST_RESULT;
      ST_RESULT:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = DIV_FIT_W;
    in_ready    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.store      = in_valid && !is_read;
        cmd.capture    = in_valid && is_read;
        cmd.factor_cfg = in_valid && is_read && !status.fit_mode;
      end
      ST_FW_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_FIT_W;
      end
      ST_FW_WAIT: begin
        cmd.div_sel    = DIV_FIT_W;
        cmd.fit_w_save = status.div_done;
      end
      ST_FH_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_FIT_H;
      end
      ST_FH_WAIT: begin
        cmd.div_sel    = DIV_FIT_H;
        cmd.fit_h_save = status.div_done;
      end
      ST_DIMS:  cmd.dims_save = 1'b1;
      ST_CHECK: cmd.check_save = 1'b1;
      ST_MX_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MAP_X;
      end
      ST_MX_WAIT: begin
        cmd.div_sel    = DIV_MAP_X;
        cmd.map_x_save = status.div_done;
      end
      ST_MY_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MAP_Y;
      end
      ST_MY_WAIT: begin
        cmd.div_sel    = DIV_MAP_Y;
        cmd.map_y_save = status.div_done;
      end
      ST_FETCH:  cmd.fetch = 1'b1;
      ST_RESULT: cmd.out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

endmodule

/* rtl/core/nnis_datapath.sv */
// datapath: config registers, frame store, factor and size arithmetic
// depends on nnis_pkg and nnis_div
module nnis_datapath #(
  parameter int MAX_DIM = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [nnis_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nnis_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [nnis_pkg::SIDE_W-1:0]      col,
  input  logic [nnis_pkg::SIDE_W-1:0]      row,
  input  logic [nnis_pkg::PIX_W-1:0]       pixel_in,
  input  nnis_pkg::cmd_t                   cmd,
  output nnis_pkg::status_t                status,
  output logic [nnis_pkg::PIX_W-1:0]       pixel_out,
  output logic                             in_range,
  output logic [nnis_pkg::DIM_REG_W-1:0]   out_width,
  output logic [nnis_pkg::DIM_REG_W-1:0]   out_height
);
  import nnis_pkg::*;

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int PROD_W = DIM_REG_W + FACTOR_BITS;
  localparam int SZ_W   = PROD_W - 8;

  logic [DIM_REG_W-1:0]   source_width;
  logic [DIM_REG_W-1:0]   source_height;
  logic [FACTOR_BITS-1:0] scale_factor;
  logic                   fit_mode;
  logic [DIM_REG_W-1:0]   target_width;
  logic [DIM_REG_W-1:0]   target_height;

  logic [DIM_REG_W-1:0]   sw_c;
  logic [DIM_REG_W-1:0]   sh_c;
  logic [SIDE_W-1:0]      col_r;
  logic [SIDE_W-1:0]      row_r;
  logic [FACTOR_BITS-1:0] factor;
  logic [FACTOR_BITS-1:0] fit_w;
  logic [DIM_W-1:0]       ow;
  logic [DIM_W-1:0]       oh;
  logic                   inr;
  logic [SIDE_W-1:0]      sx;
  logic [SIDE_W-1:0]      sy;
  logic [PIX_W-1:0]       rd_data;
  logic [PIX_W-1:0]       store [STORE_DEPTH];

  logic [PROD_W-1:0]    prod_w;
  logic [PROD_W-1:0]    prod_h;
  logic [SZ_W-1:0]      ow_full;
  logic [SZ_W-1:0]      oh_full;
  logic                 hit;
  logic [DIV_W-1:0]     div_a;
  logic [DIV_W-1:0]     div_b;
  logic [DIV_W-1:0]     quo;
  logic                 div_done;
  logic [DIM_REG_W-1:0] map_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= DIM_REG_W'(64);
      source_height <= DIM_REG_W'(64);
      scale_factor  <= FACTOR_BITS'(256);
      fit_mode      <= 1'b0;
      target_width  <= DIM_REG_W'(64);
      target_height <= DIM_REG_W'(64);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SRC_W:  source_width  <= cfg_data[DIM_REG_W-1:0];
        CFG_SRC_H:  source_height <= cfg_data[DIM_REG_W-1:0];
        CFG_FACTOR: scale_factor  <= cfg_data[FACTOR_BITS-1:0];
        CFG_FIT:    fit_mode      <= cfg_data[0];
        CFG_TGT_W:  target_width  <= cfg_data[DIM_REG_W-1:0];
        CFG_TGT_H:  target_height <= cfg_data[DIM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // source size limited to 1..64
  always_comb begin
    sw_c = source_width;
    if (source_width == '0) sw_c = DIM_REG_W'(1);
    else if (source_width > DIM_REG_W'(STORE_SIDE)) sw_c = DIM_REG_W'(STORE_SIDE);
    sh_c = source_height;
    if (source_height == '0) sh_c = DIM_REG_W'(1);
    else if (source_height > DIM_REG_W'(STORE_SIDE)) sh_c = DIM_REG_W'(STORE_SIDE);
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_FIT_W: begin
        div_a = DIV_W'({target_width, 8'h00});
        div_b = DIV_W'(sw_c);
      end
      DIV_FIT_H: begin
        div_a = DIV_W'({target_height, 8'h00});
        div_b = DIV_W'(sh_c);
      end
      DIV_MAP_X: begin
        div_a = DIV_W'({col_r, 8'h00});
        div_b = factor;
      end
      DIV_MAP_Y: begin
        div_a = DIV_W'({row_r, 8'h00});
        div_b = factor;
      end
      default: begin
        div_a = '0;
        div_b = '0;
      end
    endcase
  end

  nnis_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (quo),
    .done     (div_done)
  );

  assign map_lim = (cmd.div_sel == DIV_MAP_Y) ? sh_c : sw_c;
  assign prod_w  = PROD_W'(sw_c) * PROD_W'(factor);
  assign prod_h  = PROD_W'(sh_c) * PROD_W'(factor);
  assign ow_full = prod_w[PROD_W-1:8];
  assign oh_full = prod_h[PROD_W-1:8];
  assign hit     = (factor != '0) && (SZ_W'(col_r) < SZ_W'(ow))
                   && (SZ_W'(row_r) < SZ_W'(oh));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_r <= col;
      row_r <= row;
    end
    if (cmd.factor_cfg) begin
      factor <= scale_factor;
    end else if (cmd.fit_h_save) begin
      factor <= (quo < fit_w) ? quo : fit_w;
    end
    if (cmd.fit_w_save) begin
      fit_w <= quo;
    end
    if (cmd.dims_save) begin
      ow <= (ow_full > SZ_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(ow_full);
      oh <= (oh_full > SZ_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(oh_full);
    end
    if (cmd.check_save) begin
      inr <= hit;
    end
    if (cmd.map_x_save) begin
      sx <= (quo >= DIV_W'(map_lim)) ? SIDE_W'(map_lim - DIM_REG_W'(1)) : quo[SIDE_W-1:0];
    end
    if (cmd.map_y_save) begin
      sy <= (quo >= DIV_W'(map_lim)) ? SIDE_W'(map_lim - DIM_REG_W'(1)) : quo[SIDE_W-1:0];
    end
    if (cmd.out_load) begin
      pixel_out  <= inr ? rd_data : '0;
      in_range   <= inr;
      out_width  <= DIM_REG_W'(ow);
      out_height <= DIM_REG_W'(oh);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      store[{row, col}] <= pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rd_data <= store[{sy, sx}];
    end
  end

  assign status.fit_mode = fit_mode;
  assign status.div_done = div_done;
  assign status.hit      = hit;

endmodule

/* rtl/core/nearest_neighbor_image_scaler.sv */
// nearest-neighbor image scaler top level
// depends on nnis_pkg, nnis_ctrl, nnis_datapath
//
//   channel | handshake           | payload
//   in      | in_valid / in_ready | opcode, col, row, pixel_in
//   out     | out_valid/out_ready | pixel_out, in_range, out_width, out_height
//   cfg     | cfg_write           | cfg_index, cfg_data
//
// reads: fit divisions in fit mode, range check, then the mapping only if in range
// each division runs on the shared 16-bit divider (start, 16 steps, done):
// two for the coordinate mapping, two more for the fit factor
// one item in flight; in_ready is high only between items
// a finished result sits in the output register while the next item is taken
// synchronous reset clears control and config; the frame store is not cleared
module nearest_neighbor_image_scaler #(
  parameter int MAX_DIM = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [nnis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nnis_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            opcode,
  input  logic [nnis_pkg::SIDE_W-1:0]     col,
  input  logic [nnis_pkg::SIDE_W-1:0]     row,
  input  logic [nnis_pkg::PIX_W-1:0]      pixel_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [nnis_pkg::PIX_W-1:0]      pixel_out,
  output logic                            in_range,
  output logic [nnis_pkg::DIM_REG_W-1:0]  out_width,
  output logic [nnis_pkg::DIM_REG_W-1:0]  out_height
);
  import nnis_pkg::*;

  cmd_t    cmd;
  status_t status;

  nnis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  nnis_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .col        (col),
    .row        (row),
    .pixel_in   (pixel_in),
    .cmd        (cmd),
    .status     (status),
    .pixel_out  (pixel_out),
    .in_range   (in_range),
    .out_width  (out_width),
    .out_height (out_height)
  );

endmodule

/* rtl/core/nnis_checker.sv */
// port-level checks for the scaler, bound to the top level
// depends on nnis_pkg and nearest_neighbor_image_scaler_defines.svh
`include "nearest_neighbor_image_scaler_defines.svh"

module nnis_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        opcode,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [nnis_pkg::PIX_W-1:0]  pixel_out,
  input logic                        in_range
);
  import nnis_pkg::*;

  // a stalled result transaction holds
  `NNIS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_out) && $stable(in_range))
  // misses carry a zero pixel
  `NNIS_ASSERT_IMP(a_miss_zero, out_valid && !in_range, pixel_out == '0)
  // no result right after reset
  `NNIS_ASSERT_IMP(a_reset_empty, $past(rst), !out_valid)
  // a read occupies the block
  `NNIS_ASSERT_NEXT(a_read_busy, in_valid && in_ready && (opcode == OP_READ), !in_ready)

endmodule

bind nearest_neighbor_image_scaler nnis_checker u_checker (.*);

/* tb/sv/nearest_neighbor_image_scaler_tb.sv */
// testbench for the nearest-neighbor image scaler: a directed table, then random phases
// depends on nnis_pkg and nearest_neighbor_image_scaler; every result is checked
// field by field against an in-line predictor of the scaler or a value typed in the table
module nearest_neighbor_image_scaler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nnis_pkg::*;

  localparam int MAX_DIM       = 64;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 100;
  localparam int IDLE_PCT      = 32;
  localparam int HOLD_AT       = 150;
  localparam int HOLD_CYCLES   = 600;

  typedef struct packed {
    logic [PIX_W-1:0]     pixel;
    logic                 inr;
    logic [DIM_REG_W-1:0] w;
    logic [DIM_REG_W-1:0] h;
  } scaled_px_t;

  typedef struct {
    logic                  is_cfg;
    cfg_reg_t              idx;
    logic [CFG_DATA_W-1:0] value;
    opcode_t               op;
    logic [SIDE_W-1:0]     c;
    logic [SIDE_W-1:0]     r;
    logic [PIX_W-1:0]      pix;
    logic                  typed;
    scaled_px_t            want;
  } stim_row_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic                  opcode    = 1'b0;
  logic [SIDE_W-1:0]     col       = '0;
  logic [SIDE_W-1:0]     row       = '0;
  logic [PIX_W-1:0]      pixel_in  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      pixel_out;
  logic                  in_range;
  logic [DIM_REG_W-1:0]  out_width;
  logic [DIM_REG_W-1:0]  out_height;

  // predictor copy of the registers and the frame store
  logic [DIM_REG_W-1:0]   m_src_w  = 7'd64;
  logic [DIM_REG_W-1:0]   m_src_h  = 7'd64;
  logic [FACTOR_BITS-1:0] m_factor = 16'd256;
  logic                   m_fit    = 1'b0;
  logic [DIM_REG_W-1:0]   m_tgt_w  = 7'd64;
  logic [DIM_REG_W-1:0]   m_tgt_h  = 7'd64;
  logic [PIX_W-1:0]       shadow_store [STORE_DEPTH];
  bit                     loaded [STORE_DEPTH];

  scaled_px_t pending_pixels[$];
  stim_row_t  directed[$];
  bit         steady       = 1'b0;
  int         failures     = 0;
  int         results_seen = 0;
  int         hold_left    = 0;
  bit         hold_done    = 1'b0;
  int         cycle_count  = 0;

  nearest_neighbor_image_scaler #(.MAX_DIM(MAX_DIM)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .col       (col),
    .row       (row),
    .pixel_in  (pixel_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (pixel_out),
    .in_range  (in_range),
    .out_width (out_width),
    .out_height(out_height)
  );

  always #1 clk = ~clk;

  function automatic logic [31:0] clamp_side(logic [DIM_REG_W-1:0] v);
    if (v == 0) return 32'd1;
    if (v > STORE_SIDE) return 32'(STORE_SIDE);
    return 32'(v);
  endfunction

  function automatic logic [31:0] fit_ratio(logic [DIM_REG_W-1:0] tgt, logic [31:0] side);
    logic [31:0] q;
    q = (32'(tgt) << 8) / side;
    return (q > 32'hffff) ? 32'hffff : q;
  endfunction

  function automatic logic [31:0] scaled_dim(logic [31:0] side, logic [31:0] fac);
    logic [31:0] d;
    d = (side * fac) >> 8;
    return (d > 32'(MAX_DIM)) ? 32'(MAX_DIM) : d;
  endfunction

  function automatic logic [31:0] source_coord(logic [SIDE_W-1:0] c, logic [31:0] fac,
                                               logic [31:0] side);
    logic [31:0] s;
    s = (32'(c) << 8) / fac;
    return (s >= side) ? side - 1 : s;
  endfunction

  function automatic scaled_px_t scale_lookup(logic [SIDE_W-1:0] c, logic [SIDE_W-1:0] r,
                                              output logic [11:0] idx);
    logic [31:0] sw, sh, fw, fh, fac, ow, oh, sx, sy;
    scaled_px_t  res;
    sw = clamp_side(m_src_w);
    sh = clamp_side(m_src_h);
    if (m_fit) begin
      fw  = fit_ratio(m_tgt_w, sw);
      fh  = fit_ratio(m_tgt_h, sh);
      fac = (fw < fh) ? fw : fh;
    end else begin
      fac = 32'(m_factor);
    end
    ow        = scaled_dim(sw, fac);
    oh        = scaled_dim(sh, fac);
    res.w     = ow[DIM_REG_W-1:0];
    res.h     = oh[DIM_REG_W-1:0];
    res.inr   = (32'(c) < ow) && (32'(r) < oh) && (fac != 0);
    res.pixel = '0;
    idx       = '0;
    if (res.inr) begin
      sx        = source_coord(c, fac, sw);
      sy        = source_coord(r, fac, sh);
      idx       = {sy[5:0], sx[5:0]};
      res.pixel = shadow_store[idx];
    end
    return res;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_side();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 16'd127 : 16'd0;
      1: return 16'd64;
      2: return 16'd1;
      3: return 16'($urandom_range(0, 127));
      default: return 16'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic void row_cfg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
    directed.push_back('{1'b1, idx, v, OP_LOAD, 6'd0, 6'd0, 32'd0, 1'b0, '0});
  endfunction

  function automatic void row_item(opcode_t op, logic [SIDE_W-1:0] c, logic [SIDE_W-1:0] r,
                                   logic [PIX_W-1:0] pix);
    directed.push_back('{1'b0, CFG_SRC_W, 16'd0, op, c, r, pix, 1'b0, '0});
  endfunction

  function automatic void row_typed(logic [SIDE_W-1:0] c, logic [SIDE_W-1:0] r,
                                    scaled_px_t want);
    directed.push_back('{1'b0, CFG_SRC_W, 16'd0, OP_READ, c, r, 32'd0, 1'b1, want});
  endfunction

  // lower valid, let the block drain, then allow for work still in flight
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SRC_W:  m_src_w  = v[DIM_REG_W-1:0];
      CFG_SRC_H:  m_src_h  = v[DIM_REG_W-1:0];
      CFG_FACTOR: m_factor = v[FACTOR_BITS-1:0];
      CFG_FIT:    m_fit    = v[0];
      CFG_TGT_W:  m_tgt_w  = v[DIM_REG_W-1:0];
      CFG_TGT_H:  m_tgt_h  = v[DIM_REG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drive_item(input opcode_t op, input logic [SIDE_W-1:0] c,
                            input logic [SIDE_W-1:0] r, input logic [PIX_W-1:0] p,
                            output scaled_px_t pred);
    logic [11:0] idx;
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < IDLE_PCT) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    col      <= c;
    row      <= r;
    pixel_in <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = scale_lookup(c, r, idx);
    if (op == OP_LOAD) begin
      shadow_store[{r, c}] = p;
      loaded[{r, c}]       = 1'b1;
    end
  endtask

  // a read that maps to a never-written entry gets that entry loaded first
  task automatic send_item(opcode_t op, logic [SIDE_W-1:0] c, logic [SIDE_W-1:0] r,
                           logic [PIX_W-1:0] p, logic typed, scaled_px_t want);
    scaled_px_t  res;
    scaled_px_t  scratch;
    logic [11:0] idx;
    if (op == OP_READ) begin
      res = scale_lookup(c, r, idx);
      if (res.inr && !loaded[idx]) drive_item(OP_LOAD, idx[5:0], idx[11:6], $urandom(), scratch);
    end
    drive_item(op, c, r, p, res);
    if (op == OP_READ) pending_pixels.push_back(typed ? want : res);
  endtask

  always @(posedge clk) begin
    scaled_px_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_pixels.size() == 0) begin
          $error("result transaction with no pending read");
          failures++;
        end else begin
          want = pending_pixels.pop_front();
          if (pixel_out !== want.pixel) begin
            $error("pixel_out expected %h actual %h", want.pixel, pixel_out);
            failures++;
          end
          if (in_range !== want.inr) begin
            $error("in_range expected %0d actual %0d", want.inr, in_range);
            failures++;
          end
          if (out_width !== want.w) begin
            $error("out_width expected %0d actual %0d", want.w, out_width);
            failures++;
          end
          if (out_height !== want.h) begin
            $error("out_height expected %0d actual %0d", want.h, out_height);
            failures++;
          end
        end
      end
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    stim_row_t         rw;
    scaled_px_t        probe;
    logic [11:0]       idx;
    logic [SIDE_W-1:0] c, r;
    logic [15:0]       fac;
    int                sw, sh;

    // reset values, extremes of the pixel word
    row_item(OP_LOAD, 6'd0, 6'd0, 32'hffff_ffff);
    row_typed(6'd0, 6'd0, scaled_px_t'{32'hffff_ffff, 1'b1, 7'd64, 7'd64});
    row_item(OP_LOAD, 6'd63, 6'd63, 32'h0000_0000);
    row_typed(6'd63, 6'd63, scaled_px_t'{32'h0000_0000, 1'b1, 7'd64, 7'd64});
    row_item(OP_LOAD, 6'd63, 6'd0, 32'ha5a5_a5a5);
    row_item(OP_READ, 6'd63, 6'd0, 32'h0);
    row_item(OP_LOAD, 6'd0, 6'd63, 32'h5a5a_5a5a);
    row_item(OP_READ, 6'd0, 6'd63, 32'hffff_ffff);
    // zero factor, then the largest and the smallest nonzero factor
    row_cfg(CFG_FACTOR, 16'd0);
    row_typed(6'd0, 6'd0, '0);
    row_typed(6'd63, 6'd63, '0);
    row_cfg(CFG_FACTOR, 16'hffff);
    row_item(OP_READ, 6'd63, 6'd63, 32'h0);
    row_cfg(CFG_FACTOR, 16'd1);
    row_typed(6'd0, 6'd0, '0);
    // source sizes out of range, oversized output, then a halved output
    row_cfg(CFG_SRC_W, 16'd0);
    row_cfg(CFG_SRC_H, 16'd127);
    row_cfg(CFG_FACTOR, 16'd512);
    row_item(OP_READ, 6'd1, 6'd63, 32'h0);
    row_typed(6'd2, 6'd0, scaled_px_t'{32'h0, 1'b0, 7'd2, 7'd64});
    row_cfg(CFG_SRC_W, 16'd64);
    row_cfg(CFG_SRC_H, 16'd64);
    row_cfg(CFG_FACTOR, 16'd128);
    row_item(OP_READ, 6'd31, 6'd31, 32'h0);
    row_typed(6'd32, 6'd0, scaled_px_t'{32'h0, 1'b0, 7'd32, 7'd32});
    // fit mode: zero target, then the largest fit factor
    row_cfg(CFG_FIT, 16'd1);
    row_cfg(CFG_TGT_W, 16'd0);
    row_typed(6'd0, 6'd0, '0);
    row_cfg(CFG_TGT_W, 16'd127);
    row_cfg(CFG_TGT_H, 16'd127);
    row_cfg(CFG_SRC_W, 16'd1);
    row_item(OP_READ, 6'd0, 6'd63, 32'h0);
    row_cfg(CFG_SRC_H, 16'd1);
    row_item(OP_READ, 6'd63, 6'd63, 32'h0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      rw = directed[i];
      if (rw.is_cfg) begin
        quiesce();
        write_reg(rw.idx, rw.value);
      end else begin
        send_item(rw.op, rw.c, rw.r, rw.pix, rw.typed, rw.want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      quiesce();
      steady = (ph == 5);
      case ($urandom_range(0, 7))
        0: fac = 16'd0;
        1: fac = 16'hffff;
        2: fac = 16'd1;
        3: fac = 16'($urandom());
        default: fac = 16'($urandom_range(64, 1024));
      endcase
      write_reg(CFG_SRC_W, pick_side());
      write_reg(CFG_SRC_H, pick_side());
      write_reg(CFG_FACTOR, fac);
      write_reg(CFG_FIT, 16'(ph % 2));
      write_reg(CFG_TGT_W, pick_side());
      write_reg(CFG_TGT_H, pick_side());
      probe = scale_lookup(6'd0, 6'd0, idx);
      sw    = int'(clamp_side(m_src_w));
      sh    = int'(clamp_side(m_src_h));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 40) begin
          if ($urandom_range(0, 9) < 7) begin
            c = 6'($urandom_range(0, sw - 1));
            r = 6'($urandom_range(0, sh - 1));
          end else begin
            c = 6'($urandom());
            r = 6'($urandom());
          end
          send_item(OP_LOAD, c, r, $urandom(), 1'b0, probe);
        end else begin
          if (probe.w != 0 && probe.h != 0 && $urandom_range(0, 3) != 0) begin
            c = 6'($urandom_range(0, int'(probe.w) - 1));
            r = 6'($urandom_range(0, int'(probe.h) - 1));
          end else begin
            c = 6'($urandom());
            r = 6'($urandom());
          end
          send_item(OP_READ, c, r, $urandom(), 1'b0, probe);
        end
      end
    end

    quiesce();
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/nnis_pkg.sv
rtl/core/nnis_div.sv
rtl/core/nnis_ctrl.sv
rtl/core/nnis_datapath.sv
rtl/core/nearest_neighbor_image_scaler.sv
rtl/core/nnis_checker.sv
tb/sv/nearest_neighbor_image_scaler_tb.sv
